[rtl/core/stc_pkg.sv]
// Package for the scrolling text column generator.
// Holds shared constants, the sequencer state type, the subtractor result
// struct, the upper-case helper and the 3x8 font lookup. No dependencies.
package stc_pkg;

  // Default sizes, handed to the top level parameters
  localparam int DISPLAY_COLUMNS_DEF = 16;
  localparam int DISPLAY_ROWS_DEF    = 12;
  localparam int MAX_CHARS_DEF       = 32;

  // Fixed field widths
  localparam int KIND_W   = 3;
  localparam int CIDX_W   = 5;
  localparam int CODE_W   = 8;
  localparam int COLIDX_W = 6;
  localparam int PIX_W    = 12;
  localparam int COLOR_W  = 24;
  localparam int IVL_W    = 10;
  localparam int TLEN_W   = 6;
  localparam int POS_W    = 9;
  localparam int ALU_W    = 10;
  localparam int CFG_IDX_W = 2;

  // Font geometry
  localparam int GLYPH_ROW_OFFSET = 2;
  localparam int GLYPH_COLS       = 3;

  // Register reset values
  localparam logic [IVL_W-1:0]   IVL_RST   = IVL_W'(250);
  localparam logic [TLEN_W-1:0]  TLEN_RST  = '0;
  localparam logic [COLOR_W-1:0] COLOR_RST = 24'hFF_FFFF;
  localparam logic [IVL_W-1:0]   TICK_SAT  = '1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR    = 2'd2;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_LOAD   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_START  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_STOP   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_TICK   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RENDER = 3'd4;

  // Result types
  localparam logic RES_COLUMN = 1'b0;
  localparam logic RES_DONE   = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_LOOK,
    S_STEP,
    S_CHK,
    S_EVT
  } state_t;

  // Shared subtractor result
  typedef struct packed {
    logic                    neg;
    logic signed [ALU_W-1:0] diff;
  } alu_res_t;

  // Upper-case a byte
  function automatic logic [CODE_W-1:0] to_upper(input logic [CODE_W-1:0] ch);
    logic [CODE_W-1:0] r;
    r = ch;
    if (ch >= 8'h61 && ch <= 8'h7A) begin
      r = ch - 8'h20;
    end
    return r;
  endfunction

  // One column of the 3x8 font; unknown codes give a solid block
  function automatic logic [7:0] glyph_col(input logic [CODE_W-1:0] code,
                                           input logic [1:0] c);
    logic [23:0] g;
    logic [7:0]  r;
    unique case (code)
      "J": g = {8'h7E, 8'h81, 8'h7E};
      "E": g = {8'h81, 8'h91, 8'hFF};
      "L": g = {8'h80, 8'h80, 8'hFF};
      "Y": g = {8'h07, 8'hF8, 8'h07};
      "B": g = {8'h6E, 8'h91, 8'hFF};
      "R": g = {8'hEE, 8'h11, 8'hFF};
      "A": g = {8'hFE, 8'h11, 8'hFE};
      "C": g = {8'h81, 8'h81, 8'h7E};
      "D": g = {8'h7E, 8'h81, 8'hFF};
      "F": g = {8'h01, 8'h11, 8'hFF};
      "G": g = {8'hE1, 8'h81, 8'h7E};
      "H": g = {8'hFF, 8'h10, 8'hFF};
      "I": g = {8'hFF, 8'hFF, 8'hFF};
      "K": g = {8'hC7, 8'h38, 8'hFF};
      "M": g = {8'hFF, 8'h0E, 8'hFF};
      "N": g = {8'hFF, 8'h1C, 8'hFF};
      "O": g = {8'h7E, 8'h81, 8'h7E};
      "P": g = {8'h0E, 8'h11, 8'hFF};
      "T": g = {8'h01, 8'hFF, 8'h01};
      "U": g = {8'h7F, 8'h80, 8'h7F};
      "0": g = {8'h7E, 8'h81, 8'h7E};
      "1": g = {8'h80, 8'hFF, 8'h41};
      "2": g = {8'h9F, 8'hA1, 8'hC1};
      "3": g = {8'h6E, 8'h91, 8'h42};
      "4": g = {8'hFF, 8'h20, 8'h3F};
      "5": g = {8'h61, 8'h91, 8'h9F};
      "6": g = {8'h62, 8'h91, 8'h7E};
      "7": g = {8'h1F, 8'hE1, 8'h01};
      "8": g = {8'h6E, 8'h91, 8'h6E};
      "9": g = {8'h7E, 8'h91, 8'h4E};
      " ": g = 24'h00_0000;
      ":": g = {8'h66, 8'h66, 8'h66};
      default: g = 24'hFF_FFFF;
    endcase
    // g holds {col2, col1, col0}
    unique case (c)
      2'd0:    r = g[7:0];
      2'd1:    r = g[15:8];
      2'd2:    r = g[23:16];
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/scrolling_text_column_generator_unit.sv]
// Scrolling text marquee column generator: top level with sequencer.
// Depends on stc_pkg, stc_ram and stc_alu.
//
// Load, start, stop, ignored kinds and ticks that do not step are handled in
// the idle state alone. A tick that steps the scroll passes through the step
// and check states, and then the event state (with any output stall) when it
// reports completion. A render while scrolling walks the columns in turn: each
// column goes through the read state (shared subtractor and text RAM read)
// and the lookup state (font lookup into the output register). The block
// accepts no item until the current one has finished; a result may wait in
// the output register while the next item is taken.
module scrolling_text_column_generator_unit #(
  parameter int DISPLAY_COLUMNS = stc_pkg::DISPLAY_COLUMNS_DEF,
  parameter int DISPLAY_ROWS    = stc_pkg::DISPLAY_ROWS_DEF,
  parameter int MAX_CHARS       = stc_pkg::MAX_CHARS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration
  input  logic                             cfg_we,
  input  logic [stc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [stc_pkg::COLOR_W-1:0]      cfg_wdata,
  // input items
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [stc_pkg::KIND_W-1:0]       in_kind,
  input  logic [stc_pkg::CIDX_W-1:0]       in_char_index,
  input  logic [stc_pkg::CODE_W-1:0]       in_char_code,
  // result items
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_result_type,
  output logic [stc_pkg::COLIDX_W-1:0]     out_column_index,
  output logic [stc_pkg::PIX_W-1:0]        out_column_pixels,
  output logic [stc_pkg::COLOR_W-1:0]      out_pixel_color_res,
  output logic                             out_last
);
  import stc_pkg::*;

  localparam int CNT_W  = $clog2(DISPLAY_COLUMNS);
  localparam int ADDR_W = MAX_CHARS > 1 ? $clog2(MAX_CHARS) : 1;
  localparam int LEN_W  = $clog2(MAX_CHARS + 1);
  localparam logic [CNT_W-1:0] COL_LAST = CNT_W'(DISPLAY_COLUMNS - 1);
  localparam logic [PIX_W-1:0] ROW_MASK = PIX_W'((32'd1 << DISPLAY_ROWS) - 32'd1);
  localparam logic [POS_W-1:0] POS_START = POS_W'(DISPLAY_COLUMNS);

  // Registers
  state_t                  state_r, state_nxt;
  logic [IVL_W-1:0]        interval_r;
  logic [TLEN_W-1:0]       text_len_r;
  logic [COLOR_W-1:0]      color_r;
  logic signed [POS_W-1:0] pos_r, pos_nxt;
  logic                    active_r, active_nxt;
  logic [IVL_W-1:0]        ticks_r, ticks_nxt;
  logic [CNT_W-1:0]        col_r, col_nxt;
  logic                    hit_r, hit_nxt;
  logic [1:0]              cc_r, cc_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic                    out_type_r, out_type_nxt;
  logic [COLIDX_W-1:0]     out_idx_r, out_idx_nxt;
  logic [PIX_W-1:0]        out_pix_r, out_pix_nxt;
  logic [COLOR_W-1:0]      out_color_r, out_color_nxt;
  logic                    out_last_r, out_last_nxt;

  // Datapath signals
  logic                    in_acc;
  logic                    out_free;
  logic [LEN_W-1:0]        msg_len;
  logic signed [ALU_W-1:0] width_neg;
  logic signed [ALU_W-1:0] alu_a, alu_b;
  alu_res_t                alu_res;
  logic [7:0]              char_slot;
  logic [ADDR_W-1:0]       rd_addr;
  logic                    ram_we;
  logic                    ram_re;
  logic [CODE_W-1:0]       ram_rdata;
  logic [IVL_W-1:0]        ticks_inc;
  logic [7:0]              glyph;
  logic [PIX_W-1:0]        col_pix;

  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Message length, capped at the store depth
  assign msg_len = (7'(text_len_r) > 7'(MAX_CHARS)) ? LEN_W'(MAX_CHARS)
                                                     : LEN_W'(text_len_r);

  // Negated text width: -(4*len - 1), zero for an empty message
  assign width_neg = (msg_len == '0) ? '0
                   : ALU_W'(10'sd1 - $signed({1'b0, ALU_W'(msg_len) << 2}));

  // Operand select for the shared subtractor
  always_comb begin
    unique case (state_r)
      S_STEP: begin
        alu_a = ALU_W'(pos_r);
        alu_b = ALU_W'(1);
      end
      S_CHK: begin
        alu_a = ALU_W'(pos_r);
        alu_b = width_neg;
      end
      default: begin
        alu_a = $signed(ALU_W'(col_r));
        alu_b = ALU_W'(pos_r);
      end
    endcase
  end

  stc_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  // Character slot and column within the pitch from the relative column
  assign char_slot = alu_res.diff[ALU_W-1:2];
  assign rd_addr   = char_slot[ADDR_W-1:0];

  // Text store
  assign ram_we = in_acc && (in_kind == KIND_LOAD)
                  && (7'(in_char_index) < 7'(MAX_CHARS));
  assign ram_re = (state_r == S_RD);

  stc_ram #(
    .WIDTH (CODE_W),
    .DEPTH (MAX_CHARS)
  ) u_text (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_W'(in_char_index)),
    .wdata (to_upper(in_char_code)),
    .re    (ram_re),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Font lookup for the column in flight
  assign glyph   = glyph_col(ram_rdata, cc_r);
  assign col_pix = hit_r ? (PIX_W'({glyph, 2'b00}) & ROW_MASK) : '0;

  assign ticks_inc = (ticks_r < TICK_SAT) ? ticks_r + IVL_W'(1) : ticks_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= IVL_RST;
      text_len_r <= TLEN_RST;
      color_r    <= COLOR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INTERVAL: interval_r <= cfg_wdata[IVL_W-1:0];
        CFG_TEXT_LEN: text_len_r <= cfg_wdata[TLEN_W-1:0];
        CFG_COLOR:    color_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      active_r    <= 1'b0;
      ticks_r     <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      active_r    <= active_nxt;
      ticks_r     <= ticks_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    hit_r       <= hit_nxt;
    cc_r        <= cc_nxt;
    out_type_r  <= out_type_nxt;
    out_idx_r   <= out_idx_nxt;
    out_pix_r   <= out_pix_nxt;
    out_color_r <= out_color_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    active_nxt    = active_r;
    ticks_nxt     = ticks_r;
    col_nxt       = col_r;
    hit_nxt       = hit_r;
    cc_nxt        = cc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_type_nxt  = out_type_r;
    out_idx_nxt   = out_idx_r;
    out_pix_nxt   = out_pix_r;
    out_color_nxt = out_color_r;
    out_last_nxt  = out_last_r;
    in_ready      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_kind)
            KIND_START: begin
              pos_nxt    = POS_START;
              ticks_nxt  = '0;
              active_nxt = 1'b1;
            end
            KIND_STOP: begin
              active_nxt = 1'b0;
            end
            KIND_TICK: begin
              if (active_r) begin
                ticks_nxt = ticks_inc;
                if (ticks_inc >= interval_r) begin
                  ticks_nxt = '0;
                  state_nxt = S_STEP;
                end
              end
            end
            KIND_RENDER: begin
              if (active_r) begin
                col_nxt   = '0;
                state_nxt = S_RD;
              end
            end
            default: ;
          endcase
        end
      end

      // Relative column, text read issued
      S_RD: begin
        hit_nxt   = !alu_res.neg
                    && (char_slot < 8'(msg_len))
                    && (alu_res.diff[1:0] != 2'd3);
        cc_nxt    = alu_res.diff[1:0];
        state_nxt = S_LOOK;
      end

      // Font lookup into the output register
      S_LOOK: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_type_nxt  = RES_COLUMN;
          out_idx_nxt   = COLIDX_W'(col_r);
          out_pix_nxt   = col_pix;
          out_color_nxt = color_r;
          out_last_nxt  = (col_r == COL_LAST);
          col_nxt       = col_r + CNT_W'(1);
          state_nxt     = (col_r == COL_LAST) ? S_IDLE : S_RD;
        end
      end

      // Move one column left
      S_STEP: begin
        pos_nxt   = POS_W'(alu_res.diff);
        state_nxt = S_CHK;
      end

      // Text fully gone when pos + width is negative
      S_CHK: begin
        if (alu_res.neg) begin
          active_nxt = 1'b0;
          state_nxt  = S_EVT;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      // Completion event
      S_EVT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_type_nxt  = RES_DONE;
          out_idx_nxt   = '0;
          out_pix_nxt   = '0;
          out_color_nxt = '0;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid           = out_valid_r;
  assign out_result_type     = out_type_r;
  assign out_column_index    = out_idx_r;
  assign out_column_pixels   = out_pix_r;
  assign out_pixel_color_res = out_color_r;
  assign out_last            = out_last_r;

  // Rendering only runs while the scroll is active
  a_render_active: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOK || state_r == S_RD) |-> active_r)
    else $error("render sequencer running while scroll inactive");

  // A completion event is always the last result
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_type == RES_DONE) |-> (out_last && out_column_pixels == '0))
    else $error("completion event malformed");

  // Column masks never light rows beyond the display
  a_row_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_column_pixels & ~ROW_MASK) == '0))
    else $error("pixels above display rows");

  // A start places the text just off the right edge
  a_start_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_kind == KIND_START) |=> (active_r && pos_r == POS_START && ticks_r == '0))
    else $error("start did not reset scroll");

  // A completing check leads to the event state with the scroll stopped
  a_chk_evt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHK && alu_res.neg) |=> (state_r == S_EVT && !active_r))
    else $error("completion not reported");

endmodule

[rtl/core/stc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module stc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

[rtl/core/stc_alu.sv]
// Shared signed subtractor of the scroll sequencer.
// Depends on stc_pkg.
module stc_alu (
  input  logic signed [stc_pkg::ALU_W-1:0] a,
  input  logic signed [stc_pkg::ALU_W-1:0] b,
  output stc_pkg::alu_res_t                res
);
  import stc_pkg::*;

  logic signed [ALU_W-1:0] diff;

  // a - b, sign flag for the compares
  assign diff     = a - b;
  assign res.diff = diff;
  assign res.neg  = diff[ALU_W-1];

endmodule
